// File: design/catmull_rom_spline_evaluator_defines.svh
// assertion helpers for the spline evaluator
`ifndef CATMULL_ROM_SPLINE_EVALUATOR_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CRS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define CRS_ASSERT(label, clk, rst_n, prop)
`define CRS_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: design/crs_pkg.sv
`timescale 1ns / 1ps
package crs_pkg;
    localparam int TABLE_WORDS = 256;
    localparam int MAX_DIMS    = 4;
    localparam int AW          = $clog2(TABLE_WORDS);
    localparam int DW          = $clog2(MAX_DIMS);
    localparam int QDEPTH      = 2;

    localparam logic [0:0] FUNC_WRITE = 1'b0;
    localparam logic [0:0] FUNC_EVAL  = 1'b1;

    localparam logic CFG_DIMENSIONS = 1'b0;
    localparam logic CFG_KNOT_COUNT = 1'b1;

    // job handed from front to back
    typedef struct packed {
        logic          err;
        logic [8:0]    span;
        logic [15:0]   frac;
        logic [2:0]    dims;
    } crs_job_t;
endpackage

// File: design/crs_ram.sv
`timescale 1ns / 1ps
module crs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/crs_front.sv
`timescale 1ns / 1ps
module crs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [15:0]       position_lo,
    input  logic              position_neg,
    input  logic              position_big,
    input  logic [2:0]        dims,
    input  logic [8:0]        knots,
    input  logic              hold,
    output logic              job_valid,
    input  logic              job_stall,
    output crs_pkg::crs_job_t job
);
    import crs_pkg::*;

    // stage 1: clamp and classify, stage 2: register product
    logic             s_reg, s_next;
    crs_job_t         j_reg, j_next;
    logic [16:0]      pos;
    logic [25:0]      t;
    logic             bad;
    logic [11:0]      area;

    assign area = 12'(knots) * 12'(dims);
    assign bad  = (knots < 9'd4) || (dims == 3'd0) || (dims > 3'(MAX_DIMS))
                  || (area > 12'(TABLE_WORDS));
    assign pos  = position_neg ? 17'd0 : (position_big ? 17'h10000 : {1'b0, position_lo});
    assign t    = 26'(pos) * 26'(knots - 9'd4);

    // a knot write waits until no evaluation is pending, so the table stays in order
    assign in_stall  = (s_reg && job_stall) || ((s_reg || hold) && func == FUNC_WRITE);
    assign job_valid = s_reg;
    assign job       = j_reg;

    always_comb
    begin
        s_next = s_reg;
        j_next = j_reg;
        if (s_reg && !job_stall)
        begin
            s_next = 1'b0;
        end
        if (in_valid && !in_stall && func == FUNC_EVAL)
        begin
            s_next      = 1'b1;
            j_next.err  = bad;
            j_next.span = t[24:16];
            j_next.frac = t[15:0];
            j_next.dims = dims;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= 1'b0;
        end
        else
        begin
            s_reg <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
    end
endmodule

// File: design/crs_queue.sv
`timescale 1ns / 1ps
`include "catmull_rom_spline_evaluator_defines.svh"
module crs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  crs_pkg::crs_job_t din,
    output logic              nonempty,
    input  logic              pop,
    output crs_pkg::crs_job_t dout
);
    import crs_pkg::*;

    crs_job_t   q_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full     = (cnt_reg == 2'(QDEPTH));
    assign nonempty = (cnt_reg != 2'd0);
    assign dout     = q_reg[rp_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign wp_next  = do_push ? ~wp_reg : wp_reg;
    assign rp_next  = do_pop ? ~rp_reg : rp_reg;
    assign cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= din;
        end
    end

    `CRS_NEVER(a_cnt_range, clk, rst_n, cnt_reg > 2'(QDEPTH))
    `CRS_ASSERT(a_fill, clk, rst_n, do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
    `CRS_ASSERT(a_drain, clk, rst_n, do_pop && !do_push |=> cnt_reg == $past(cnt_reg) - 2'd1)
endmodule

// File: design/crs_back.sv
`timescale 1ns / 1ps
`include "catmull_rom_spline_evaluator_defines.svh"
module crs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_pop,
    input  crs_pkg::crs_job_t job,
    output logic [7:0]        raddr,
    input  logic [15:0]       rdata,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [17:0]       value,
    output logic [1:0]        dim_index,
    output logic              last,
    output logic              error
);
    import crs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_COEF = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]         st_reg, st_next;
    logic [1:0]         k_reg, k_next;      // knot being read
    logic [2:0]         rk_reg, rk_next;    // knots received
    logic [1:0]         dim_reg, dim_next;
    logic [1:0]         step_reg, step_next;
    logic signed [15:0] p_reg [4];
    logic signed [21:0] h_reg, h_next;
    logic signed [39:0] m_reg, m_next;
    logic signed [19:0] b_reg, c_reg;
    logic               ov_reg, ov_next;
    logic [17:0]        v_reg, v_next;
    logic               l_reg, l_next, e_reg, e_next;
    logic [1:0]         di_reg, di_next;
    logic [11:0]        addr_w;
    logic signed [19:0] a_w, b_w, c_w;
    logic signed [22:0] hs_w;
    logic signed [19:0] v_w;
    logic               lastdim;

    assign addr_w  = (12'(job.span) + 12'(k_reg)) * 12'(job.dims) + 12'(dim_reg);
    assign raddr   = addr_w[7:0];
    assign lastdim = (3'(dim_reg) + 3'd1 == job.dims);
    assign a_w = -20'(p_reg[0]) + 20'sd3 * p_reg[1] - 20'sd3 * p_reg[2] + 20'(p_reg[3]);
    assign b_w = 20'sd2 * p_reg[0] - 20'sd5 * p_reg[1] + 20'sd4 * p_reg[2] - 20'(p_reg[3]);
    assign c_w = 20'(p_reg[2]) - 20'(p_reg[0]);
    assign hs_w = 23'(m_reg >>> 16);
    assign v_w  = 20'(p_reg[1]) + 20'(h_reg >>> 1);

    assign out_valid = ov_reg;
    assign value     = v_reg;
    assign dim_index = di_reg;
    assign last      = l_reg;
    assign error     = e_reg;

    always_comb
    begin
        st_next   = st_reg;
        k_next    = k_reg;
        rk_next   = rk_reg;
        dim_next  = dim_reg;
        step_next = step_reg;
        h_next    = h_reg;
        m_next    = m_reg;
        ov_next   = ov_reg && out_stall;
        v_next    = v_reg;
        l_next    = l_reg;
        e_next    = e_reg;
        di_next   = di_reg;
        job_pop   = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.err)
                    begin
                        st_next = ST_OUT;
                    end
                    else
                    begin
                        st_next = ST_READ;
                        k_next  = 2'd1;
                        rk_next = 3'd0;
                    end
                end
            end
            ST_READ:
            begin
                // reads issued one per cycle, data lands in the cycle after each read
                k_next  = k_reg + 2'd1;
                rk_next = rk_reg + 3'd1;
                if (rk_reg == 3'd3)
                begin
                    st_next = ST_COEF;
                end
            end
            ST_COEF:
            begin
                h_next    = 22'(a_w);
                step_next = 2'd0;
                st_next   = ST_MUL;
            end
            ST_MUL:
            begin
                m_next  = 40'(h_reg) * $signed({1'b0, job.frac});
                st_next = ST_ADD;
            end
            ST_ADD:
            begin
                unique case (step_reg)
                    2'd0:    h_next = 22'(hs_w + 23'(b_reg));
                    2'd1:    h_next = 22'(hs_w + 23'(c_reg));
                    default: h_next = 22'(hs_w);
                endcase
                step_next = step_reg + 2'd1;
                st_next   = (step_reg == 2'd2) ? ST_OUT : ST_MUL;
            end
            ST_OUT:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    if (job.err)
                    begin
                        v_next  = 18'd0;
                        di_next = 2'd0;
                        l_next  = 1'b1;
                        e_next  = 1'b1;
                        job_pop = 1'b1;
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        v_next  = (v_w > 20'sd131071) ? 18'h1FFFF :
                                  (v_w < -20'sd131072) ? 18'h20000 : v_w[17:0];
                        di_next = dim_reg;
                        l_next  = lastdim;
                        e_next  = 1'b0;
                        if (lastdim)
                        begin
                            dim_next = 2'd0;
                            job_pop  = 1'b1;
                            st_next  = ST_IDLE;
                        end
                        else
                        begin
                            // idle issues the first knot read of the next coordinate
                            dim_next = dim_reg + 2'd1;
                            k_next   = 2'd0;
                            st_next  = ST_IDLE;
                        end
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
        if (st_reg == ST_IDLE || st_reg == ST_OUT)
        begin
            if (st_next != ST_READ)
            begin
                k_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ov_reg   <= 1'b0;
            dim_reg  <= 2'd0;
            k_reg    <= 2'd0;
            rk_reg   <= 3'd0;
            step_reg <= 2'd0;
        end
        else
        begin
            st_reg   <= st_next;
            ov_reg   <= ov_next;
            dim_reg  <= dim_next;
            k_reg    <= k_next;
            rk_reg   <= rk_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg  <= h_next;
        m_reg  <= m_next;
        v_reg  <= v_next;
        l_reg  <= l_next;
        e_reg  <= e_next;
        di_reg <= di_next;
        if (st_reg == ST_READ)
        begin
            p_reg[rk_reg[1:0]] <= $signed(rdata);
        end
        if (st_reg == ST_COEF)
        begin
            b_reg <= b_w;
            c_reg <= c_w;
        end
    end

    `CRS_ASSERT(a_hold, clk, rst_n, ov_reg && out_stall |=> ov_reg && $stable(v_reg))
    `CRS_ASSERT(a_pop_out, clk, rst_n, job_pop |=> ov_reg && l_reg)
    `CRS_NEVER(a_pop_empty, clk, rst_n, job_pop && !job_valid)
endmodule

// File: design/catmull_rom_spline_evaluator.sv
`timescale 1ns / 1ps
// catmull-rom spline evaluator
// input channel: in_valid/in_stall with func, word_index, knot_value, position.
// a write transaction (func 0) stores one q8.8 knot word and gives no result.
// an evaluate transaction (func 1) gives one result per dimension on the
// output channel (out_valid/out_stall), dim_index counting up, last on the final
// one; bad knot or dimension counts or table overflow give one error result.
// configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// each dimension passes through the back end in order: an address step in idle,
// four serial knot reads, a coefficient step, three multiply/add passes of one
// shared multiplier and an output step. a two-entry job queue sits between the
// position scaler and the evaluator, so new evaluations are taken while the
// back end works or waits on a stalled output; a write transaction waits
// until no evaluation is pending.
// reset clears control state; the knot table content stays undefined until
// written. dimensions resets to 1, knot_count to 0.
// stalled output holds its result; in_stall rises when queue and front are full.
module catmull_rom_spline_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  word_index,
    input  logic signed [15:0] knot_value,
    input  logic signed [31:0] position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [17:0] value,
    output logic [1:0]  dim_index,
    output logic        last,
    output logic        error,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import crs_pkg::*;

    logic [2:0]  dims_reg;
    logic [8:0]  knots_reg;
    logic        f_valid, f_stall, q_full, q_ne, pop;
    crs_job_t    f_job, q_job;
    logic [7:0]  raddr;
    logic [15:0] rdata;
    logic        we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg  <= 3'd1;
            knots_reg <= 9'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DIMENSIONS)
            begin
                dims_reg <= cfg_data[2:0];
            end
            else
            begin
                knots_reg <= cfg_data;
            end
        end
    end

    assign we      = in_valid && !in_stall && func == FUNC_WRITE;
    assign f_stall = q_full;

    crs_ram #(.WIDTH(16), .DEPTH(TABLE_WORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (word_index),
        .wdata (knot_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    crs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .position_lo  (position[15:0]),
        .position_neg (position[31]),
        .position_big (position[30:16] != 15'd0),
        .dims         (dims_reg),
        .knots        (knots_reg),
        .hold         (q_ne),
        .job_valid    (f_valid),
        .job_stall    (f_stall),
        .job          (f_job)
    );

    crs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_valid),
        .full     (q_full),
        .din      (f_job),
        .nonempty (q_ne),
        .pop      (pop),
        .dout     (q_job)
    );

    crs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_ne),
        .job_pop   (pop),
        .job       (q_job),
        .raddr     (raddr),
        .rdata     (rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .dim_index (dim_index),
        .last      (last),
        .error     (error)
    );
endmodule

// File: bench/crs_checker.sv
`timescale 1ns / 1ps
module crs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               func,
    input  logic [7:0]         word_index,
    input  logic signed [15:0] knot_value,
    input  logic signed [31:0] position,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [17:0] value,
    input  logic [1:0]         dim_index,
    input  logic               last,
    input  logic               error,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);
    import crs_pkg::*;

    typedef struct {
        logic signed [17:0] value;
        logic [1:0]         dim_index;
        logic               last;
        logic               error;
    } coord_result_t;

    logic signed [15:0] knot_mem [TABLE_WORDS];
    logic [2:0]         dims_reg;
    logic [8:0]         knots_reg;
    coord_result_t      expected_coords [$];

    initial begin
        fail_count   = 0;
        results_seen = 0;
    end

    assign pending = expected_coords.size();

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic longint knot_at(input longint idx);
        if (idx < TABLE_WORDS)
            return longint'(knot_mem[idx]);
        return 0;
    endfunction

    // works out the coordinates of one evaluation and queues them
    task automatic predict_curve(input logic signed [31:0] pos_in);
        coord_result_t r;
        longint pos, t, f, span, p0, p1, p2, p3, a, b, c, h, v;
        int d;
        d = dims_reg;
        if (knots_reg < 4 || d == 0 || d > MAX_DIMS || knots_reg * d > TABLE_WORDS) begin
            r.value = '0;
            r.dim_index = '0;
            r.last = 1'b1;
            r.error = 1'b1;
            expected_coords.push_back(r);
            return;
        end
        pos = longint'(pos_in);
        if (pos < 0)
            pos = 0;
        else if (pos > 65536)
            pos = 65536;
        t = pos * (longint'(knots_reg) - 4);
        span = t >>> 16;
        f = t & 64'hFFFF;
        for (int i = 0; i < d; i++) begin
            p0 = knot_at((span + 0) * d + i);
            p1 = knot_at((span + 1) * d + i);
            p2 = knot_at((span + 2) * d + i);
            p3 = knot_at((span + 3) * d + i);
            a = -p0 + 3 * p1 - 3 * p2 + p3;
            b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c = p2 - p0;
            h = ((a * f) >>> 16) + b;
            h = ((h * f) >>> 16) + c;
            h = (h * f) >>> 16;
            v = p1 + (h >>> 1);
            if (v > 131071)
                v = 131071;
            if (v < -131072)
                v = -131072;
            r.value = v[17:0];
            r.dim_index = i[1:0];
            r.last = (i + 1 == d);
            r.error = 1'b0;
            expected_coords.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        coord_result_t e;
        if (!rst_n) begin
            dims_reg  <= 3'd1;
            knots_reg <= 9'd0;
            expected_coords.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_DIMENSIONS)
                    dims_reg <= cfg_data[2:0];
                else
                    knots_reg <= cfg_data;
            end
            if (in_valid && !in_stall) begin
                if (func == FUNC_WRITE)
                    knot_mem[word_index] = knot_value;
                else
                    predict_curve(position);
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_coords.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d dim %0d",
                                              value, dim_index));
                end
                else begin
                    e = expected_coords.pop_front();
                    if (value !== e.value)
                        report_mismatch($sformatf("value %0d, want %0d (dim %0d)",
                                                  value, e.value, e.dim_index));
                    if (dim_index !== e.dim_index)
                        report_mismatch($sformatf("dim_index %0d, want %0d",
                                                  dim_index, e.dim_index));
                    if (last !== e.last)
                        report_mismatch($sformatf("last %0b, want %0b", last, e.last));
                    if (error !== e.error)
                        report_mismatch($sformatf("error %0b, want %0b", error, e.error));
                end
            end
        end
    end
endmodule

// File: bench/catmull_rom_spline_evaluator_tb.sv
`timescale 1ns / 1ps
module catmull_rom_spline_evaluator_tb;
    import crs_pkg::*;

    // knot words written before any evaluation reads them
    localparam int FILL_WORDS = 64;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               func = FUNC_WRITE;
    logic [7:0]         word_index = '0;
    logic signed [15:0] knot_value = '0;
    logic signed [31:0] position = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [17:0] value;
    logic [1:0]         dim_index;
    logic               last;
    logic               error;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_DIMENSIONS;
    logic [8:0]         cfg_data = '0;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent = 0;
    int evals_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_cycle = 0;

    always #10 clk = ~clk;

    catmull_rom_spline_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .word_index(word_index), .knot_value(knot_value), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .dim_index(dim_index), .last(last), .error(error),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    crs_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .word_index(word_index), .knot_value(knot_value), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .dim_index(dim_index), .last(last), .error(error),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // output backpressure in one of four stall modes, redrawn at random
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= (stall_cycle % 5) < 2;
        endcase
    end

    task automatic send_item(input logic f, input logic [7:0] idx,
                             input logic [15:0] kv, input logic [31:0] pos);
        int gap;
        in_valid <= 1'b1;
        func <= f;
        word_index <= idx;
        knot_value <= kv;
        position <= pos;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (f == FUNC_EVAL)
            evals_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // lowers valid, lets every result drain, then allows for write-only tails
    task automatic settle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_config(input logic [2:0] dims, input logic [8:0] knots);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DIMENSIONS;
        cfg_data <= {6'd0, dims};
        @(posedge clk);
        cfg_index <= CFG_KNOT_COUNT;
        cfg_data <= knots;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_position;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd65536;
            2: return $urandom();
            3: return 32'hFFFF_FFFF - $urandom_range(0, 70000);
            4: return 32'd65536 + $urandom_range(1, 1000);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    task automatic random_phase(input logic [2:0] dims, input logic [8:0] knots, input int n);
        int          area;
        logic [31:0] pos;
        area = int'(dims) * int'(knots);
        set_config(dims, knots);
        repeat (n) begin
            // wide tables are evaluated on the first span only, inside the filled words
            pos = (area > FILL_WORDS) ? 32'd0 : pick_position();
            if ($urandom_range(0, 9) < 7)
                send_item(FUNC_EVAL, 8'($urandom()), 16'($urandom()), pos);
            else
                send_item(FUNC_WRITE, 8'($urandom()), 16'($urandom()), $urandom());
        end
        settle();
    endtask

    initial
    begin : timeout_guard
        #20ms;
        $display("catmull_rom_spline_evaluator_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0] d;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config has no knots: error result
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'd32768);
        settle();

        // fill the low part of the table so no evaluation reads an unwritten word
        for (int i = 0; i < FILL_WORDS; i++)
            send_item(FUNC_WRITE, i[7:0], 16'($urandom()), $urandom());

        // extreme knots over a single span
        send_item(FUNC_WRITE, 8'd0, 16'h8000, 32'd0);
        send_item(FUNC_WRITE, 8'd1, 16'h7FFF, 32'd0);
        send_item(FUNC_WRITE, 8'd2, 16'h8000, 32'd0);
        send_item(FUNC_WRITE, 8'd3, 16'h7FFF, 32'd0);
        settle();
        set_config(3'd1, 9'd4);
        send_item(FUNC_EVAL, 8'hFF, 16'hFFFF, 32'd0);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'd32768);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'd49152);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'd65535);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'd65536);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'hFFFF_FFFF);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'h8000_0000);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'h7FFF_FFFF);
        send_item(FUNC_EVAL, 8'd0, 16'd0, 32'd65537);
        settle();

        // boundaries of the knot count and dimension checks
        random_phase(3'd1, 9'd3, 3);
        random_phase(3'd1, 9'd256, 6);
        random_phase(3'd1, 9'd257, 3);
        random_phase(3'd2, 9'd128, 6);
        random_phase(3'd4, 9'd64, 6);
        random_phase(3'd4, 9'd65, 3);
        random_phase(3'd3, 9'd85, 6);
        random_phase(3'd0, 9'd10, 3);
        random_phase(3'd5, 9'd10, 3);
        random_phase(3'd7, 9'd20, 3);
        random_phase(3'd4, 9'd4, 6);
        random_phase(3'd2, 9'd511, 3);

        repeat (6) begin
            d = 3'($urandom_range(1, 4));
            if ($urandom_range(0, 7) == 0)
                random_phase(3'($urandom()), 9'($urandom()), 16);
            else if ($urandom_range(0, 2) == 0)
                random_phase(d, 9'($urandom_range(4, 8)), 16);
            else
                random_phase(d, 9'($urandom_range(4, FILL_WORDS / d)), 16);
        end

        $display("sent %0d transactions (%0d evaluations), checked %0d results",
                 items_sent, evals_sent, results_seen);
        $display("configs covered dims 0..7 and knot counts 0..511, incl error limits");
        if (fail_count == 0)
            $display("catmull_rom_spline_evaluator_tb passed");
        else
            $display("catmull_rom_spline_evaluator_tb failed");
        $finish;
    end
endmodule
